// ----- sv/cbm_pkg.sv -----
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types, address constants and write decode for the bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int unsigned PRESCALE_PERIOD = 341;
  localparam int unsigned PRESC_W         = 10;
  localparam int unsigned SUM_W           = 11;

  localparam logic [15:0] ADDR_MASK   = 16'hF010;
  localparam logic [15:0] ADDR_SOUND  = 16'h9030;
  localparam logic [15:0] ADDR_CHR_LO = 16'hA000;
  localparam logic [15:0] ADDR_CHR_HI = 16'hDFFF;
  localparam logic [15:0] ADDR_PRG0   = 16'h8000;
  localparam logic [15:0] ADDR_PRG1   = 16'h8010;
  localparam logic [15:0] ADDR_PRG2   = 16'h9000;
  localparam logic [15:0] ADDR_SNDIDX = 16'h9010;
  localparam logic [15:0] ADDR_MIRROR = 16'hE000;
  localparam logic [15:0] ADDR_LATCH  = 16'hE010;
  localparam logic [15:0] ADDR_CTRL   = 16'hF000;
  localparam logic [15:0] ADDR_ACK    = 16'hF010;
  localparam logic [15:0] ADDR_ROM_LO = 16'h8000;
  localparam logic [15:0] ADDR_FIXED  = 16'hE000;
  localparam logic [7:0]  FIXED_BANK  = 8'hFF;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_PRG   = 2'd2,
    ACT_CHR   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    WR_NONE   = 4'd0,
    WR_CHR    = 4'd1,
    WR_SOUND  = 4'd2,
    WR_PRG0   = 4'd3,
    WR_PRG1   = 4'd4,
    WR_PRG2   = 4'd5,
    WR_SNDIDX = 4'd6,
    WR_MIRROR = 4'd7,
    WR_LATCH  = 4'd8,
    WR_CTRL   = 4'd9,
    WR_ACK    = 4'd10
  } wr_op_t;

  typedef struct packed {
    logic        valid;
    action_t     act;
    wr_op_t      op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [6:0]  cycles;
  } cmd_t;

  // address bit 3 folds into bit 4
  function automatic logic [15:0] fold_addr(input logic [15:0] addr);
    fold_addr = {addr[15:5], addr[4] | addr[3], addr[3:0]};
  endfunction

  function automatic wr_op_t wr_decode(input logic [15:0] addr);
    logic [15:0] a;
    a = fold_addr(addr);
    if (a >= ADDR_CHR_LO && a <= ADDR_CHR_HI) begin
      wr_decode = WR_CHR;
    end else if (a == ADDR_SOUND) begin
      wr_decode = WR_SOUND;
    end else begin
      case (a & ADDR_MASK)
        ADDR_PRG0:   wr_decode = WR_PRG0;
        ADDR_PRG1:   wr_decode = WR_PRG1;
        ADDR_PRG2:   wr_decode = WR_PRG2;
        ADDR_SNDIDX: wr_decode = WR_SNDIDX;
        ADDR_MIRROR: wr_decode = WR_MIRROR;
        ADDR_LATCH:  wr_decode = WR_LATCH;
        ADDR_CTRL:   wr_decode = WR_CTRL;
        ADDR_ACK:    wr_decode = WR_ACK;
        default:     wr_decode = WR_NONE;
      endcase
    end
  endfunction

endpackage

// ----- sv/cbm_bank_file.sv -----
// ----------------------------------------------------------------------------
// cbm_bank_file
// CHR/PRG bank registers, mirroring and sound index; bank lookup for queries.
// ----------------------------------------------------------------------------
module cbm_bank_file (
  input  logic          clk,
  input  logic          rst_n,
  input  cbm_pkg::cmd_t cmd,
  output logic [7:0]    bank_number,
  output logic [1:0]    mirror_nxt,
  output logic [7:0]    sound_index
);

  logic [7:0] chr_bank_r [8];
  logic [7:0] prg_bank_r [3];
  logic [1:0] mirror_r;
  logic [7:0] sound_index_r;
  logic [15:0] wa;
  logic [2:0]  chr_slot;
  logic [13:0] ca;

  assign wa       = cbm_pkg::fold_addr(cmd.addr);
  assign chr_slot = {~wa[13], wa[12], wa[4]};
  assign ca       = cmd.addr[13:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) chr_bank_r[i] <= 8'(i);
      for (int i = 0; i < 3; i++) prg_bank_r[i] <= 8'(i);
      mirror_r      <= '0;
      sound_index_r <= '0;
    end else if (cmd.valid) begin
      case (cmd.op)
        cbm_pkg::WR_CHR:    chr_bank_r[chr_slot] <= cmd.data;
        cbm_pkg::WR_PRG0:   prg_bank_r[0] <= cmd.data;
        cbm_pkg::WR_PRG1:   prg_bank_r[1] <= cmd.data;
        cbm_pkg::WR_PRG2:   prg_bank_r[2] <= cmd.data;
        cbm_pkg::WR_SNDIDX: sound_index_r <= cmd.data;
        cbm_pkg::WR_MIRROR: mirror_r <= cmd.data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bank_number = '0;
    case (cmd.act)
      cbm_pkg::ACT_PRG: begin
        if (cmd.addr < cbm_pkg::ADDR_ROM_LO) begin
          bank_number = '0;
        end else if (cmd.addr >= cbm_pkg::ADDR_FIXED) begin
          bank_number = cbm_pkg::FIXED_BANK;
        end else begin
          case (cmd.addr[14:13])
            2'd0:    bank_number = prg_bank_r[0];
            2'd1:    bank_number = prg_bank_r[1];
            default: bank_number = prg_bank_r[2];
          endcase
        end
      end
      cbm_pkg::ACT_CHR: begin
        bank_number = ca[13] ? 8'd0 : chr_bank_r[ca[12:10]];
      end
      default: bank_number = '0;
    endcase
  end

  assign mirror_nxt  = (cmd.valid && cmd.op == cbm_pkg::WR_MIRROR) ? cmd.data[1:0] : mirror_r;
  assign sound_index = sound_index_r;

endmodule

// ----- sv/cbm_irq_timer.sv -----
// ----------------------------------------------------------------------------
// cbm_irq_timer
// Prescaler, 8-bit IRQ counter with reload latch, and IRQ control.
// ----------------------------------------------------------------------------
module cbm_irq_timer (
  input  logic          clk,
  input  logic          rst_n,
  input  cbm_pkg::cmd_t cmd,
  output logic          irq_pending_nxt
);

  localparam logic [cbm_pkg::SUM_W-1:0] P1 = cbm_pkg::SUM_W'(cbm_pkg::PRESCALE_PERIOD);
  localparam logic [cbm_pkg::SUM_W-1:0] P2 = cbm_pkg::SUM_W'(2 * cbm_pkg::PRESCALE_PERIOD);

  logic [cbm_pkg::PRESC_W-1:0] prescaler_r, prescaler_nxt;
  logic [7:0] irq_counter_r, irq_counter_nxt;
  logic [7:0] irq_reload_r, irq_reload_nxt;
  logic       irq_enable_r, irq_enable_nxt;
  logic       ack_reenable_r, ack_reenable_nxt;
  logic       irq_pending_r;

  logic [cbm_pkg::SUM_W-1:0] sum, presc_sub;
  logic       wrap1, wrap2, ovf1, ovf2;
  logic [7:0] cnt1, cnt_a, cnt2, cnt_b;

  // at most two prescaler wraps per tick for 7-bit cycle counts
  assign sum   = cbm_pkg::SUM_W'(prescaler_r) + cbm_pkg::SUM_W'({cmd.cycles, 1'b0})
               + cbm_pkg::SUM_W'(cmd.cycles);
  assign wrap1 = sum >= P1;
  assign wrap2 = sum >= P2;
  assign presc_sub = sum - (wrap2 ? P2 : (wrap1 ? P1 : '0));

  assign cnt1  = irq_counter_r + 8'd1;
  assign ovf1  = wrap1 && (cnt1 == 8'd0);
  assign cnt_a = ovf1 ? irq_reload_r : cnt1;
  assign cnt2  = cnt_a + 8'd1;
  assign ovf2  = wrap2 && (cnt2 == 8'd0);
  assign cnt_b = ovf2 ? irq_reload_r : cnt2;

  always_comb begin
    prescaler_nxt    = prescaler_r;
    irq_counter_nxt  = irq_counter_r;
    irq_reload_nxt   = irq_reload_r;
    irq_enable_nxt   = irq_enable_r;
    ack_reenable_nxt = ack_reenable_r;
    irq_pending_nxt  = irq_pending_r;
    if (cmd.valid) begin
      if (cmd.act == cbm_pkg::ACT_TICK) begin
        if (irq_enable_r) begin
          prescaler_nxt   = presc_sub[cbm_pkg::PRESC_W-1:0];
          irq_counter_nxt = wrap2 ? cnt_b : (wrap1 ? cnt_a : irq_counter_r);
          irq_pending_nxt = irq_pending_r | ovf1 | ovf2;
        end
      end else begin
        case (cmd.op)
          cbm_pkg::WR_LATCH: begin
            irq_reload_nxt  = cmd.data;
            irq_pending_nxt = 1'b0;
          end
          cbm_pkg::WR_CTRL: begin
            irq_enable_nxt   = cmd.data[1];
            ack_reenable_nxt = cmd.data[0];
            if (cmd.data[1]) irq_counter_nxt = irq_reload_r;
            prescaler_nxt    = '0;
            irq_pending_nxt  = 1'b0;
          end
          cbm_pkg::WR_ACK: begin
            irq_enable_nxt  = ack_reenable_r;
            irq_pending_nxt = 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescaler_r    <= '0;
      irq_counter_r  <= '0;
      irq_reload_r   <= '0;
      irq_enable_r   <= 1'b0;
      ack_reenable_r <= 1'b0;
      irq_pending_r  <= 1'b0;
    end else begin
      prescaler_r    <= prescaler_nxt;
      irq_counter_r  <= irq_counter_nxt;
      irq_reload_r   <= irq_reload_nxt;
      irq_enable_r   <= irq_enable_nxt;
      ack_reenable_r <= ack_reenable_nxt;
      irq_pending_r  <= irq_pending_nxt;
    end
  end

  a_presc_range: assert property (@(posedge clk) disable iff (!rst_n)
    prescaler_r < cbm_pkg::PRESC_W'(cbm_pkg::PRESCALE_PERIOD))
    else $error("prescaler out of range");

  a_disabled_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.valid && cmd.act == cbm_pkg::ACT_TICK && !irq_enable_r)
      |=> ($stable(irq_counter_r) && $stable(prescaler_r)))
    else $error("disabled timer advanced");

endmodule

// ----- sv/cartridge_bank_mapper_irq.sv -----
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq
// Cartridge bank mapper with prescaled IRQ counter and sound write forwarding.
// ----------------------------------------------------------------------------
// Input channel (in_*): one request per bus write, tick, PRG query or CHR
// query, accepted when in_valid is high and in_stall is low.
// Output channel (out_*): exactly one result per request, in order, taken
// when out_valid is high and out_stall is low.
// Each accepted request passes through the input register, then the result
// register, which raises out_valid. Throughput: one request per cycle while
// the output is not stalled; the mapper state is updated as a request moves
// from the input register to the result register, so the following request sees it.
// A stall on the output holds the result register; the input register still
// takes one more request, after which in_stall rises until the result is
// taken.
// Reset (rst_n low, synchronous) empties both registers and restores the
// bank registers to their identity mapping and the IRQ logic to idle.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_irq (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [6:0]  in_tick_cycles,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_irq_line,
  output logic [1:0]  out_mirror_mode,
  output logic [7:0]  out_bank_number,
  output logic        out_sound_write_valid,
  output logic [7:0]  out_sound_reg_index,
  output logic [7:0]  out_sound_reg_data
);

  logic        s1_valid_r;
  logic [1:0]  s1_action_r;
  logic [15:0] s1_address_r;
  logic [7:0]  s1_data_r;
  logic [6:0]  s1_cycles_r;

  logic        out_valid_r;
  logic        irq_line_r;
  logic [1:0]  mirror_r;
  logic [7:0]  bank_r;
  logic        snd_valid_r;
  logic [7:0]  snd_index_r;
  logic [7:0]  snd_data_r;

  logic          advance;
  cbm_pkg::cmd_t cmd;
  logic [7:0]    bank_number;
  logic [1:0]    mirror_nxt;
  logic [7:0]    sound_index;
  logic          irq_pending_nxt;
  logic          snd_write;

  assign advance  = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;

  always_comb begin
    cmd.valid  = advance;
    cmd.act    = cbm_pkg::action_t'(s1_action_r);
    cmd.op     = (cmd.act == cbm_pkg::ACT_WRITE) ? cbm_pkg::wr_decode(s1_address_r)
                                                 : cbm_pkg::WR_NONE;
    cmd.addr   = s1_address_r;
    cmd.data   = s1_data_r;
    cmd.cycles = s1_cycles_r;
  end

  assign snd_write = (cmd.op == cbm_pkg::WR_SOUND);

  cbm_bank_file u_banks (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .bank_number (bank_number),
    .mirror_nxt  (mirror_nxt),
    .sound_index (sound_index)
  );

  cbm_irq_timer u_timer (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .irq_pending_nxt (irq_pending_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action_r  <= in_action;
      s1_address_r <= in_address;
      s1_data_r    <= in_data;
      s1_cycles_r  <= in_tick_cycles;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      irq_line_r  <= irq_pending_nxt;
      mirror_r    <= mirror_nxt;
      bank_r      <= bank_number;
      snd_valid_r <= snd_write;
      snd_index_r <= snd_write ? sound_index : 8'd0;
      snd_data_r  <= snd_write ? s1_data_r : 8'd0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_irq_line          = irq_line_r;
  assign out_mirror_mode       = mirror_r;
  assign out_bank_number       = bank_r;
  assign out_sound_write_valid = snd_valid_r;
  assign out_sound_reg_index   = snd_index_r;
  assign out_sound_reg_data    = snd_data_r;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !(out_valid_r && out_stall)) |=> out_valid_r)
    else $error("request left input register without a result");

  a_sound_no_bank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sound_write_valid) |-> (out_bank_number == 8'd0))
    else $error("sound write carries a bank number");

endmodule

// ----- tb/sv/cartridge_bank_mapper_irq_test.sv -----
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_irq_test
// Self-checking bench for the cartridge bank mapper. A short table of directed
// requests covers the address extremes, every request kind, unmapped writes,
// the sound forward, oversized ticks and the IRQ path. A long random run of
// mostly well-formed register traffic follows. Every result is checked field
// by field against its typed table result or an in-bench model of the mapper,
// with random gaps and stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_irq_test;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cbm_pkg::action_t act;
    logic [15:0]      addr;
    logic [7:0]       data;
    logic [6:0]       cycles;
  } request_t;

  typedef struct packed {
    logic       irq;
    logic [1:0] mirror;
    logic [7:0] bank;
    logic       snd_valid;
    logic [7:0] snd_index;
    logic [7:0] snd_data;
  } mapper_result_t;

  typedef struct packed {
    logic           typed;
    request_t       req;
    mapper_result_t res;
  } stim_row_t;

  localparam int NUM_DIRECTED = 25;
  localparam int NUM_RANDOM   = 1450;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [15:0] in_address;
  logic [7:0]  in_data;
  logic [6:0]  in_tick_cycles;
  logic        out_valid;
  logic        out_stall;
  logic        out_irq_line;
  logic [1:0]  out_mirror_mode;
  logic [7:0]  out_bank_number;
  logic        out_sound_write_valid;
  logic [7:0]  out_sound_reg_index;
  logic [7:0]  out_sound_reg_data;

  cartridge_bank_mapper_irq uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_action             (in_action),
    .in_address            (in_address),
    .in_data               (in_data),
    .in_tick_cycles        (in_tick_cycles),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_irq_line          (out_irq_line),
    .out_mirror_mode       (out_mirror_mode),
    .out_bank_number       (out_bank_number),
    .out_sound_write_valid (out_sound_write_valid),
    .out_sound_reg_index   (out_sound_reg_index),
    .out_sound_reg_data    (out_sound_reg_data)
  );

  // mapper state mirror
  logic [7:0]  chr_bank [8];
  logic [7:0]  prg_bank [3];
  logic [1:0]  m_mirror;
  logic [7:0]  m_sound_index;
  logic [7:0]  m_irq_reload;
  logic [7:0]  m_irq_counter;
  logic        m_irq_enable;
  logic        m_ack_reenable;
  int unsigned m_prescaler;
  logic        m_irq_pending;

  mapper_result_t expected_results[$];
  stim_row_t      directed_rows [NUM_DIRECTED];
  int             err_count;
  int             results_seen;
  int             tx_calm;
  int             rx_calm;
  bit             long_hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                                results_seen, name, got, want));
    end
  endtask

  function automatic void reset_mapper();
    for (int i = 0; i < 8; i++) chr_bank[i] = 8'(i);
    for (int i = 0; i < 3; i++) prg_bank[i] = 8'(i);
    m_mirror       = '0;
    m_sound_index  = '0;
    m_irq_reload   = '0;
    m_irq_counter  = '0;
    m_irq_enable   = 1'b0;
    m_ack_reenable = 1'b0;
    m_prescaler    = 0;
    m_irq_pending  = 1'b0;
  endfunction

  function automatic mapper_result_t step_mapper(input request_t rq);
    mapper_result_t r;
    logic [15:0]    a;
    logic [1:0]     chr_hi;
    r = '0;
    case (rq.act)
      cbm_pkg::ACT_WRITE: begin
        a = rq.addr | {11'd0, rq.addr[3], 4'd0};
        if (a >= cbm_pkg::ADDR_CHR_LO && a <= cbm_pkg::ADDR_CHR_HI) begin
          chr_hi = a[13:12] - 2'd2;
          chr_bank[{chr_hi, a[4]}] = rq.data;
        end else if (a == cbm_pkg::ADDR_SOUND) begin
          r.snd_valid = 1'b1;
          r.snd_index = m_sound_index;
          r.snd_data  = rq.data;
        end else begin
          case (a & cbm_pkg::ADDR_MASK)
            cbm_pkg::ADDR_PRG0:   prg_bank[0] = rq.data;
            cbm_pkg::ADDR_PRG1:   prg_bank[1] = rq.data;
            cbm_pkg::ADDR_PRG2:   prg_bank[2] = rq.data;
            cbm_pkg::ADDR_SNDIDX: m_sound_index = rq.data;
            cbm_pkg::ADDR_MIRROR: m_mirror = rq.data[1:0];
            cbm_pkg::ADDR_LATCH: begin
              m_irq_reload  = rq.data;
              m_irq_pending = 1'b0;
            end
            cbm_pkg::ADDR_CTRL: begin
              m_irq_enable   = rq.data[1];
              m_ack_reenable = rq.data[0];
              if (rq.data[1]) m_irq_counter = m_irq_reload;
              m_prescaler    = 0;
              m_irq_pending  = 1'b0;
            end
            cbm_pkg::ADDR_ACK: begin
              m_irq_enable  = m_ack_reenable;
              m_irq_pending = 1'b0;
            end
            default: ;
          endcase
        end
      end
      cbm_pkg::ACT_TICK: begin
        if (m_irq_enable) begin
          m_prescaler += 3 * rq.cycles;
          while (m_prescaler >= cbm_pkg::PRESCALE_PERIOD) begin
            m_prescaler -= cbm_pkg::PRESCALE_PERIOD;
            m_irq_counter++;
            if (m_irq_counter == 8'd0) begin
              m_irq_pending = 1'b1;
              m_irq_counter = m_irq_reload;
            end
          end
        end
      end
      cbm_pkg::ACT_PRG: begin
        if (rq.addr < cbm_pkg::ADDR_ROM_LO) r.bank = 8'd0;
        else if (rq.addr >= cbm_pkg::ADDR_FIXED) r.bank = cbm_pkg::FIXED_BANK;
        else r.bank = prg_bank[int'((rq.addr - cbm_pkg::ADDR_ROM_LO) >> 13)];
      end
      default: begin
        if (!rq.addr[13]) r.bank = chr_bank[rq.addr[12:10]];
      end
    endcase
    r.irq    = m_irq_pending;
    r.mirror = m_mirror;
    return r;
  endfunction

  // mostly short gaps, a few long ones, and stretches with none
  function automatic int gap_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(30, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic request_t rand_request();
    request_t rq;
    int       kind;
    int       tgt;
    rq.act    = cbm_pkg::action_t'($urandom_range(0, 3));
    rq.addr   = 16'($urandom);
    rq.data   = 8'($urandom);
    rq.cycles = 7'($urandom_range(0, 113));
    if ($urandom_range(0, 9) == 0) rq.cycles = 7'($urandom_range(114, 127));
    kind = $urandom_range(0, 99);
    if (kind < 5) return rq;
    if (kind < 43) begin
      rq.act = cbm_pkg::ACT_WRITE;
      tgt = $urandom_range(0, 99);
      if (tgt < 25) rq.addr = 16'($urandom_range(int'(cbm_pkg::ADDR_CHR_LO),
                                                 int'(cbm_pkg::ADDR_CHR_HI)));
      else if (tgt < 32) rq.addr = cbm_pkg::ADDR_PRG0 | (rq.addr & 16'h0FE7);
      else if (tgt < 38) rq.addr = cbm_pkg::ADDR_PRG1 | (rq.addr & 16'h0FEF);
      else if (tgt < 44) rq.addr = cbm_pkg::ADDR_PRG2 | (rq.addr & 16'h0FE7);
      else if (tgt < 52) rq.addr = cbm_pkg::ADDR_SNDIDX | (rq.addr & 16'h0FCF);
      else if (tgt < 62) rq.addr = cbm_pkg::ADDR_SOUND;
      else if (tgt < 70) rq.addr = cbm_pkg::ADDR_MIRROR | (rq.addr & 16'h0FE7);
      else if (tgt < 76) begin
        rq.addr = cbm_pkg::ADDR_LATCH | (rq.addr & 16'h0FEF);
        if ($urandom_range(0, 9) < 6) rq.data = 8'($urandom_range(8'hF8, 8'hFF));
      end else if (tgt < 80) begin
        rq.addr = cbm_pkg::ADDR_CTRL | (rq.addr & 16'h0FE7);
        if ($urandom_range(0, 9) < 8) rq.data[1] = 1'b1;
      end else if (tgt < 86) rq.addr = cbm_pkg::ADDR_ACK | (rq.addr & 16'h0FEF);
    end else if (kind < 78) begin
      rq.act = cbm_pkg::ACT_TICK;
    end else if (kind < 89) begin
      rq.act = cbm_pkg::ACT_PRG;
    end else begin
      rq.act = cbm_pkg::ACT_CHR;
    end
    return rq;
  endfunction

  task automatic offer_request(input request_t rq, input logic typed,
                               input mapper_result_t typed_res);
    mapper_result_t pred;
    in_valid       <= 1'b1;
    in_action      <= rq.act;
    in_address     <= rq.addr;
    in_data        <= rq.data;
    in_tick_cycles <= rq.cycles;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = step_mapper(rq);
    expected_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    mapper_result_t got;
    mapper_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_irq_line, out_mirror_mode, out_bank_number,
             out_sound_write_valid, out_sound_reg_index, out_sound_reg_data};
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d with no request outstanding", results_seen));
      end else begin
        want = expected_results.pop_front();
        check_field("irq_line", got.irq, want.irq);
        check_field("mirror_mode", got.mirror, want.mirror);
        check_field("bank_number", got.bank, want.bank);
        check_field("sound_write_valid", got.snd_valid, want.snd_valid);
        check_field("sound_reg_index", got.snd_index, want.snd_index);
        check_field("sound_reg_data", got.snd_data, want.snd_data);
      end
      results_seen++;
    end
  end

  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      n = gap_len(rx_calm);
      // long hold-off so the block backs up into in_stall
      if (!long_hold_done && results_seen >= 400) begin
        n = 60;
        long_hold_done = 1'b1;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin
    int wait_cycles;
    err_count      = 0;
    results_seen   = 0;
    tx_calm        = 0;
    rx_calm        = 0;
    long_hold_done = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = cbm_pkg::ACT_WRITE;
    in_address     = '0;
    in_data        = '0;
    in_tick_cycles = '0;
    reset_mapper();

    // typed, request {act, addr, data, cycles},
    // result {irq, mirror, bank, snd_valid, snd_index, snd_data}
    directed_rows = '{
      '{1'b1, '{cbm_pkg::ACT_PRG,   16'h8000, 8'h00, 7'd0},
        '{1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 8'h00}},
      '{1'b1, '{cbm_pkg::ACT_PRG,   16'hA000, 8'h00, 7'd0},
        '{1'b0, 2'd0, 8'h01, 1'b0, 8'h00, 8'h00}},
      '{1'b1, '{cbm_pkg::ACT_PRG,   16'hE000, 8'h00, 7'd0},
        '{1'b0, 2'd0, 8'hFF, 1'b0, 8'h00, 8'h00}},
      '{1'b1, '{cbm_pkg::ACT_PRG,   16'hFFFF, 8'h00, 7'd0},
        '{1'b0, 2'd0, 8'hFF, 1'b0, 8'h00, 8'h00}},
      '{1'b1, '{cbm_pkg::ACT_PRG,   16'h7FFF, 8'h00, 7'd0},
        '{1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 8'h00}},
      '{1'b1, '{cbm_pkg::ACT_CHR,   16'h1C00, 8'h00, 7'd0},
        '{1'b0, 2'd0, 8'h07, 1'b0, 8'h00, 8'h00}},
      '{1'b1, '{cbm_pkg::ACT_CHR,   16'h2000, 8'h00, 7'd0},
        '{1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 8'h00}},
      '{1'b1, '{cbm_pkg::ACT_CHR,   16'hFFFF, 8'h00, 7'd0},
        '{1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 8'h00}},
      '{1'b1, '{cbm_pkg::ACT_CHR,   16'h4400, 8'h00, 7'd0},
        '{1'b0, 2'd0, 8'h01, 1'b0, 8'h00, 8'h00}},
      '{1'b1, '{cbm_pkg::ACT_TICK,  16'h0000, 8'h00, 7'd127},
        '{1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 8'h00}},
      '{1'b1, '{cbm_pkg::ACT_WRITE, 16'h0000, 8'hFF, 7'd0},
        '{1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 8'h00}},
      '{1'b1, '{cbm_pkg::ACT_WRITE, 16'h9010, 8'h2A, 7'd0},
        '{1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 8'h00}},
      '{1'b1, '{cbm_pkg::ACT_WRITE, 16'h9030, 8'hFF, 7'd0},
        '{1'b0, 2'd0, 8'h00, 1'b1, 8'h2A, 8'hFF}},
      '{1'b1, '{cbm_pkg::ACT_WRITE, 16'hE000, 8'hFF, 7'd0},
        '{1'b0, 2'd3, 8'h00, 1'b0, 8'h00, 8'h00}},
      '{1'b0, '{cbm_pkg::ACT_WRITE, 16'h8008, 8'h55, 7'd0},   '0},
      '{1'b0, '{cbm_pkg::ACT_WRITE, 16'hA008, 8'h80, 7'd0},   '0},
      '{1'b0, '{cbm_pkg::ACT_WRITE, 16'hDFFF, 8'hFF, 7'd0},   '0},
      '{1'b0, '{cbm_pkg::ACT_PRG,   16'hA000, 8'h00, 7'd0},   '0},
      '{1'b0, '{cbm_pkg::ACT_CHR,   16'h1C00, 8'h00, 7'd0},   '0},
      '{1'b0, '{cbm_pkg::ACT_WRITE, 16'hE010, 8'hFE, 7'd0},   '0},
      '{1'b0, '{cbm_pkg::ACT_WRITE, 16'hF000, 8'h03, 7'd0},   '0},
      '{1'b0, '{cbm_pkg::ACT_TICK,  16'hFFFF, 8'hFF, 7'd127}, '0},
      '{1'b0, '{cbm_pkg::ACT_TICK,  16'h0000, 8'h00, 7'd127}, '0},
      '{1'b0, '{cbm_pkg::ACT_WRITE, 16'hF010, 8'h00, 7'd0},   '0},
      '{1'b0, '{cbm_pkg::ACT_WRITE, 16'hF000, 8'h00, 7'd0},   '0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
      idle_sender(gap_len(tx_calm));
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      offer_request(rand_request(), 1'b0, '0);
      idle_sender(gap_len(tx_calm));
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
